// ===== src/aminv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_pkg
// Shared widths, latencies, types and the saturation helper for the affine
// matrix inverse pipeline.
// ----------------------------------------------------------------------------
package aminv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DEN_W     = 64;
    localparam int DIV_W     = DEN_W + WORD_W;
    localparam int PROD_W    = 2 * WORD_W;

    // Cycles from a stage input to its registered output
    localparam int DET_LAT  = 2;
    localparam int DIV_LAT  = WORD_W + 2;
    localparam int TRN_LAT  = 2;
    localparam int PIPE_LAT = DET_LAT + DIV_LAT + TRN_LAT + 1;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [DEN_W-1:0] mag;
        logic             neg;
        logic             zero;
    } t_det;

    // Sign and magnitude to a saturated two's complement word
    function automatic t_word sat_word(input logic neg, input logic ovf,
                                       input logic [WORD_W-1:0] mag);
        t_word res;
        if (neg) begin
            if (ovf || mag[WORD_W-1]) begin
                res = {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
                res = t_word'(-mag);
            end
        end else begin
            if (ovf || mag[WORD_W-1]) begin
                res = {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                res = t_word'(mag);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/aminv_det.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_det
// Exact determinant a*d - b*c in two stages: products, then sign/magnitude.
// ----------------------------------------------------------------------------
module aminv_det import aminv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_word i_a,
    input  wire t_word i_b,
    input  wire t_word i_c,
    input  wire t_word i_d,
    output t_det       o_det
);

    logic signed [PROD_W-1:0] r_ad;
    logic signed [PROD_W-1:0] r_bc;
    logic signed [PROD_W:0]   n_diff;
    logic [PROD_W:0]          n_abs;
    t_det                     r_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad <= i_a * i_d;
            r_bc <= i_b * i_c;
        end
    end

    always_comb begin
        n_diff = {r_ad[PROD_W-1], r_ad} - {r_bc[PROD_W-1], r_bc};
        n_abs  = n_diff[PROD_W] ? (PROD_W+1)'(-n_diff) : n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det.mag  <= n_abs[DEN_W-1:0];
            r_det.neg  <= n_diff[PROD_W];
            r_det.zero <= (n_diff == '0);
        end
    end

    assign o_det = r_det;

endmodule
`default_nettype wire

// ===== src/aminv_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_div
// Pipelined restoring divider: (num << 2F) / det, one quotient bit a stage,
// truncated toward zero and saturated to a signed word.
// ----------------------------------------------------------------------------
module aminv_div import aminv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_word i_num,
    input  wire logic  i_negate,
    input  wire t_det  i_det,
    output t_word      o_quot
);

    logic [DIV_W-1:0]  r_rem [0:WORD_W];
    logic [DEN_W-1:0]  r_den [0:WORD_W];
    logic [WORD_W-1:0] r_q   [0:WORD_W];
    logic              r_ovf [0:WORD_W];
    logic              r_neg [0:WORD_W];
    t_word             r_out;

    logic [WORD_W-1:0] n_mag;
    logic              n_nneg;
    logic [DIV_W-1:0]  n_num;

    always_comb begin
        n_mag  = i_num[WORD_W-1] ? (WORD_W)'(-i_num) : (WORD_W)'(i_num);
        n_nneg = i_negate ? (i_num > 0) : i_num[WORD_W-1];
        n_num  = DIV_W'(n_mag) << (2 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_den[0] <= i_det.mag;
            r_q[0]   <= '0;
            r_ovf[0] <= (n_num >= {i_det.mag, {WORD_W{1'b0}}});
            r_neg[0] <= (n_mag != '0) && (n_nneg != i_det.neg);
        end
    end

    for (genvar k = 1; k <= WORD_W; k++) begin : g_bit
        localparam int BIT = WORD_W - k;
        logic [DIV_W-1:0]  trial;
        logic              ge;
        logic [WORD_W-1:0] q_set;

        always_comb begin
            trial = DIV_W'(r_den[k-1]) << BIT;
            ge    = r_rem[k-1] >= trial;
            q_set = r_q[k-1] | (WORD_W'(ge) << BIT);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? r_rem[k-1] - trial : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= q_set;
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= sat_word(r_neg[WORD_W], r_ovf[WORD_W], r_q[WORD_W]);
        end
    end

    assign o_quot = r_out;

endmodule
`default_nettype wire

// ===== src/aminv_trans.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aminv_trans
// Inverse translation -(x*p + y*q) >> F, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module aminv_trans import aminv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_word i_x,
    input  wire t_word i_p,
    input  wire t_word i_y,
    input  wire t_word i_q,
    output t_word      o_res
);

    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [PROD_W+1:0] n_sum;
    logic [PROD_W+1:0]        n_abs;
    logic [PROD_W+1:0]        n_shr;
    t_word                    r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= i_x * i_p;
            r_p2 <= i_y * i_q;
        end
    end

    always_comb begin
        n_sum = -((PROD_W+2)'(r_p1) + (PROD_W+2)'(r_p2));
        n_abs = n_sum[PROD_W+1] ? (PROD_W+2)'(-n_sum) : n_sum;
        n_shr = n_abs >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= sat_word(n_sum[PROD_W+1], |n_shr[PROD_W+1:WORD_W],
                              n_shr[WORD_W-1:0]);
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== src/affine_matrix_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of a 2D affine matrix in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_m_a..i_m_ty (6 x 32b)
//  out     | source    | o_out_valid / i_out_ready  | o_inv_a..o_inv_ty, o_invertible
//
// One beat enters per cycle while the output is not stalled. A beat passes
// through the determinant's product and sign/magnitude registers, the dividers'
// input, bit-per-stage and result registers, the translation's product and result registers and the output register.
// Reset clears only the stage valid bits; data registers carry no reset.
// The whole pipe advances together; a stall at the output holds every stage,
// so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module affine_matrix_inverse import aminv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_word i_m_a,
    input  wire t_word i_m_b,
    input  wire t_word i_m_c,
    input  wire t_word i_m_d,
    input  wire t_word i_m_tx,
    input  wire t_word i_m_ty,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_word      o_inv_a,
    output t_word      o_inv_b,
    output t_word      o_inv_c,
    output t_word      o_inv_d,
    output t_word      o_inv_tx,
    output t_word      o_inv_ty,
    output logic       o_invertible
);

    localparam int SIDE_LAT = DET_LAT + DIV_LAT;

    logic                r_vld [0:PIPE_LAT-1];
    logic                en;

    t_det                det;
    t_word               q_a, q_b, q_c, q_d;
    t_word               t_x, t_y;

    // Operands and flags that wait beside the determinant, the dividers and the translation
    t_word               r_a [0:DET_LAT-1];
    t_word               r_b [0:DET_LAT-1];
    t_word               r_c [0:DET_LAT-1];
    t_word               r_d [0:DET_LAT-1];
    t_word               r_tx [0:SIDE_LAT-1];
    t_word               r_ty [0:SIDE_LAT-1];
    logic                r_zero [DET_LAT:SIDE_LAT+TRN_LAT-1];
    t_word               r_la [0:TRN_LAT-1];
    t_word               r_lb [0:TRN_LAT-1];
    t_word               r_lc [0:TRN_LAT-1];
    t_word               r_ld [0:TRN_LAT-1];

    t_word               r_oa, r_ob, r_oc, r_od, r_otx, r_oty;
    logic                r_oinv;

    // Advance the pipe unless a finished beat is held at the output
    assign en          = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    aminv_det u_det (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_m_a),
        .i_b   (i_m_b),
        .i_c   (i_m_c),
        .i_d   (i_m_d),
        .o_det (det)
    );

    // Delay lines for operands and the singular flag
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0]  <= i_m_a;
            r_b[0]  <= i_m_b;
            r_c[0]  <= i_m_c;
            r_d[0]  <= i_m_d;
            r_tx[0] <= i_m_tx;
            r_ty[0] <= i_m_ty;
            for (int i = 1; i < DET_LAT; i++) begin
                r_a[i] <= r_a[i-1];
                r_b[i] <= r_b[i-1];
                r_c[i] <= r_c[i-1];
                r_d[i] <= r_d[i-1];
            end
            for (int i = 1; i < SIDE_LAT; i++) begin
                r_tx[i] <= r_tx[i-1];
                r_ty[i] <= r_ty[i-1];
            end
            r_zero[DET_LAT] <= det.zero;
            for (int i = DET_LAT + 1; i < SIDE_LAT + TRN_LAT; i++) begin
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // Linear part: d/det, -b/det, -c/det, a/det
    aminv_div u_div_a (
        .i_clk (i_clk), .i_en (en), .i_num (r_d[DET_LAT-1]), .i_negate (1'b0),
        .i_det (det), .o_quot (q_a)
    );
    aminv_div u_div_b (
        .i_clk (i_clk), .i_en (en), .i_num (r_b[DET_LAT-1]), .i_negate (1'b1),
        .i_det (det), .o_quot (q_b)
    );
    aminv_div u_div_c (
        .i_clk (i_clk), .i_en (en), .i_num (r_c[DET_LAT-1]), .i_negate (1'b1),
        .i_det (det), .o_quot (q_c)
    );
    aminv_div u_div_d (
        .i_clk (i_clk), .i_en (en), .i_num (r_a[DET_LAT-1]), .i_negate (1'b0),
        .i_det (det), .o_quot (q_d)
    );

    // Translation from the saturated linear elements
    aminv_trans u_trans_x (
        .i_clk (i_clk), .i_en (en),
        .i_x (r_tx[SIDE_LAT-1]), .i_p (q_a),
        .i_y (r_ty[SIDE_LAT-1]), .i_q (q_c),
        .o_res (t_x)
    );
    aminv_trans u_trans_y (
        .i_clk (i_clk), .i_en (en),
        .i_x (r_tx[SIDE_LAT-1]), .i_p (q_b),
        .i_y (r_ty[SIDE_LAT-1]), .i_q (q_d),
        .o_res (t_y)
    );

    // Hold the linear results while the translation completes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_la[0] <= q_a;
            r_lb[0] <= q_b;
            r_lc[0] <= q_c;
            r_ld[0] <= q_d;
            for (int i = 1; i < TRN_LAT; i++) begin
                r_la[i] <= r_la[i-1];
                r_lb[i] <= r_lb[i-1];
                r_lc[i] <= r_lc[i-1];
                r_ld[i] <= r_ld[i-1];
            end
        end
    end

    // Output register: drop everything to zero for a singular matrix
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zero[SIDE_LAT+TRN_LAT-1]) begin
                r_oa   <= '0;
                r_ob   <= '0;
                r_oc   <= '0;
                r_od   <= '0;
                r_otx  <= '0;
                r_oty  <= '0;
                r_oinv <= 1'b0;
            end else begin
                r_oa   <= r_la[TRN_LAT-1];
                r_ob   <= r_lb[TRN_LAT-1];
                r_oc   <= r_lc[TRN_LAT-1];
                r_od   <= r_ld[TRN_LAT-1];
                r_otx  <= t_x;
                r_oty  <= t_y;
                r_oinv <= 1'b1;
            end
        end
    end

    assign o_inv_a      = r_oa;
    assign o_inv_b      = r_ob;
    assign o_inv_c      = r_oc;
    assign o_inv_d      = r_od;
    assign o_inv_tx     = r_otx;
    assign o_inv_ty     = r_oty;
    assign o_invertible = r_oinv;

endmodule
`default_nettype wire

// ===== tb/affine_matrix_inverse_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_tb
// Streams 2D affine matrices into the inverse pipeline and checks every
// output beat against an exact wide-integer inverse computed on the side.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_tb import aminv_pkg::*;;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        t_word a, b, c, d, tx, ty;
    } t_matrix;

    typedef struct packed {
        t_word a, b, c, d, tx, ty;
        logic  ok;
    } t_inverse;

    localparam t_word ONE   = t_word'(1 << FRAC_BITS);
    localparam t_word W_MAX = 32'sh7FFF_FFFF;
    localparam t_word W_MIN = 32'sh8000_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_word i_m_a = '0, i_m_b = '0, i_m_c = '0, i_m_d = '0, i_m_tx = '0, i_m_ty = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_word o_inv_a, o_inv_b, o_inv_c, o_inv_d, o_inv_tx, o_inv_ty;
    logic  o_invertible;

    t_inverse pending_inv[$];
    int       mismatches = 0;
    bit       steady = 1'b0;    // set: neither side idles

    affine_matrix_inverse dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Saturate a wide value to one signed word
    function automatic t_word clamp(input t_wide v);
        if (v > t_wide'(W_MAX)) return W_MAX;
        if (v < t_wide'(W_MIN)) return W_MIN;
        return t_word'(v);
    endfunction

    // Exact inverse: quotients and translation truncated toward zero
    function automatic t_inverse invert_matrix(input t_matrix m);
        t_inverse r;
        t_wide    det, sum;
        det = t_wide'(m.a) * t_wide'(m.d) - t_wide'(m.b) * t_wide'(m.c);
        r = '0;
        if (det == 0) return r;
        r.ok = 1'b1;
        r.a  = clamp((t_wide'(m.d)  <<< (2 * FRAC_BITS)) / det);
        r.b  = clamp((-t_wide'(m.b) <<< (2 * FRAC_BITS)) / det);
        r.c  = clamp((-t_wide'(m.c) <<< (2 * FRAC_BITS)) / det);
        r.d  = clamp((t_wide'(m.a)  <<< (2 * FRAC_BITS)) / det);
        sum  = -(t_wide'(m.tx) * t_wide'(r.a) + t_wide'(m.ty) * t_wide'(r.c));
        r.tx = clamp(sum / (t_wide'(1) <<< FRAC_BITS));
        sum  = -(t_wide'(m.tx) * t_wide'(r.b) + t_wide'(m.ty) * t_wide'(r.d));
        r.ty = clamp(sum / (t_wide'(1) <<< FRAC_BITS));
        return r;
    endfunction

    // Send one matrix beat; returns at the falling edge after acceptance
    task automatic send_matrix(input t_matrix m);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {i_m_a, i_m_b, i_m_c, i_m_d, i_m_tx, i_m_ty} <= m;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_inv.push_back(invert_matrix(m));
        @(negedge i_clk);
    endtask

    function automatic t_word rand_word();
        return t_word'($urandom());
    endfunction

    // Linear element near unit scale, with a sign
    function automatic t_word rand_scale();
        return t_word'($urandom_range(0, 1 << 19)) - t_word'(1 << 18);
    endfunction

    task automatic test_directed();
        t_matrix m[$];
        m.push_back('{ONE, 0, 0, ONE, 0, 0});                 // identity
        m.push_back('{ONE, 0, 0, ONE, ONE * 3, -ONE * 5});    // pure translation
        m.push_back('{0, 0, 0, 0, ONE, ONE});                 // all-zero, singular
        m.push_back('{ONE, ONE * 2, ONE, ONE * 2, 7, 9});     // dependent rows, singular
        m.push_back('{ONE * 2, 0, 0, ONE * 4, ONE, ONE});     // diagonal
        m.push_back('{0, ONE * 2, -ONE, 0, ONE * 3, ONE});    // anti-diagonal
        m.push_back('{1, 0, 0, 1, 0, 0});                     // tiny det, saturates high
        m.push_back('{-1, 0, 0, 1, W_MAX, W_MIN});            // tiny det, mixed signs
        m.push_back('{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX});
        m.push_back('{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN});
        m.push_back('{W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MAX});
        m.push_back('{W_MAX, 0, 0, W_MAX, W_MAX, W_MAX});     // huge det, small inverse
        m.push_back('{W_MIN, 0, 0, W_MIN, -1, -1});
        m.push_back('{0, W_MIN, W_MAX, 0, 1, -1});
        m.push_back('{-1, -1, -1, -1, -1, -1});
        m.push_back('{0, 1, 1, 0, W_MAX, W_MIN});             // anti-diagonal, tiny det
        m.push_back('{ONE, ONE, 0, ONE, ONE, 0});             // shear
        foreach (m[k]) send_matrix(m[k]);
    endtask

    // Well-formed transforms near unit scale with arbitrary translation
    task automatic test_scaled(input int n);
        t_matrix m;
        repeat (n) begin
            m = '{rand_scale(), rand_scale(), rand_scale(), rand_scale(),
                  rand_word(), rand_word()};
            send_matrix(m);
        end
    endtask

    // Full-range words, with some rows forced dependent and some small diagonals
    task automatic test_full_range(input int n);
        t_matrix m;
        repeat (n) begin
            m = '{rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word()};
            case ($urandom_range(0, 7))
                0: begin m.c = m.a; m.d = m.b; end
                1: begin m.a = t_word'($urandom_range(0, 7)) - 3; m.b = 0; m.c = 0;
                         m.d = t_word'($urandom_range(0, 7)) - 3; end
                default: ;
            endcase
            send_matrix(m);
        end
    endtask

    // Hold the sender until the pipe has fully drained
    task automatic test_drain_pause();
        test_scaled(20);
        i_in_valid <= 1'b0;
        while (pending_inv.size() != 0) @(negedge i_clk);
        test_scaled(20);
    endtask

    task automatic test_no_idle(input int n);
        steady = 1'b1;
        test_full_range(n);
        steady = 1'b0;
    endtask

    // Result side: random stall before each beat unless steady is set
    initial begin
        int k;
        forever begin
            k = steady ? 0 : $urandom_range(0, 4);
            if (k != 0) begin
                i_out_ready <= 1'b0;
                repeat (k) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Check each output beat against the oldest expected inverse
    always @(posedge i_clk) begin
        t_inverse want, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_inv_a, o_inv_b, o_inv_c, o_inv_d, o_inv_tx, o_inv_ty, o_invertible};
            if (pending_inv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %p", got);
            end else begin
                want = pending_inv.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int wait_cyc;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_scaled(600);
        test_drain_pause();
        test_full_range(500);
        test_no_idle(150);
        test_scaled(150);
        i_in_valid <= 1'b0;
        wait_cyc = 0;
        while (pending_inv.size() != 0 && wait_cyc < 10000) begin
            @(negedge i_clk);
            wait_cyc++;
        end
        repeat (PIPE_LAT + 10) @(negedge i_clk);
        if (mismatches == 0 && pending_inv.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
